/* rtl/core/tfp_pkg.sv */
// ----------------------------------------------------------------------------
// tfp_pkg
// Shared types, event codes, character constants and helper functions of the
// text record frame parser.
// ----------------------------------------------------------------------------
package tfp_pkg;

    localparam int NAME_CAPACITY_DEF  = 16;
    localparam int VALUE_CAPACITY_DEF = 32;
    localparam int TAG_LENGTH         = 8;

    localparam logic [3:0] EV_NONE       = 4'd0;
    localparam logic [3:0] EV_NAME_CHAR  = 4'd1;
    localparam logic [3:0] EV_NAME_END   = 4'd2;
    localparam logic [3:0] EV_VALUE_CHAR = 4'd3;
    localparam logic [3:0] EV_KEPT       = 4'd4;
    localparam logic [3:0] EV_DROPPED    = 4'd5;
    localparam logic [3:0] EV_TAG        = 4'd6;
    localparam logic [3:0] EV_GOOD       = 4'd7;
    localparam logic [3:0] EV_BAD        = 4'd8;
    localparam logic [3:0] EV_EMPTY      = 4'd9;
    localparam logic [3:0] EV_HEX        = 4'd10;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] char_out;
        logic [7:0] running_sum;
    } t_result;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_OFS;
        end
        return r;
    endfunction

    // Characters of the checksum tag name, CHECKSUM
    function automatic logic [7:0] tag_char(input logic [2:0] idx);
        logic [7:0] r;
        unique case (idx)
            3'd0:    r = 8'h43;
            3'd1:    r = 8'h48;
            3'd2:    r = 8'h45;
            3'd3:    r = 8'h43;
            3'd4:    r = 8'h4B;
            3'd5:    r = 8'h53;
            3'd6:    r = 8'h55;
            default: r = 8'h4D;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/tfp_parser.sv */
// ----------------------------------------------------------------------------
// tfp_parser
// Frame state machine, byte sum and name/value length tracking. Produces the
// result of one byte combinationally and advances its state on each beat.
// ----------------------------------------------------------------------------
module tfp_parser #(
    parameter int NAME_CAPACITY  = 16,
    parameter int VALUE_CAPACITY = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic [7:0]       i_rx_byte,
    output tfp_pkg::t_result o_res
);
    import tfp_pkg::*;

    localparam int NL_W = $clog2(NAME_CAPACITY + 1);
    localparam int VL_W = $clog2(VALUE_CAPACITY + 1);
    localparam logic [NL_W-1:0] NAME_CAP  = NL_W'(NAME_CAPACITY);
    localparam logic [VL_W-1:0] VALUE_CAP = VL_W'(VALUE_CAPACITY);
    localparam logic [NL_W-1:0] TAG_LEN   = NL_W'(TAG_LENGTH);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_BEGIN = 3'd1;
    localparam logic [2:0] ST_NAME  = 3'd2;
    localparam logic [2:0] ST_VALUE = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_HEX   = 3'd5;

    logic [2:0]      r_state, n_state;
    logic [7:0]      r_sum, n_sum;
    logic [NL_W-1:0] r_name_len, n_name_len;
    logic [VL_W-1:0] r_value_len, n_value_len;
    logic            r_tag, n_tag;
    logic            r_any_kept, n_any_kept;

    logic [2:0] eff_state;
    logic [7:0] c;
    logic [7:0] sum_add;
    logic [3:0] ev;
    logic [7:0] ch;

    always_comb begin
        c         = upcase(i_rx_byte);
        sum_add   = r_sum + i_rx_byte;
        // a colon aborts to hex mode except where it is the checksum byte
        eff_state = (i_rx_byte == CH_COLON && r_state != ST_CHECK) ? ST_HEX : r_state;

        n_state     = r_state;
        n_sum       = (eff_state == ST_HEX) ? r_sum : sum_add;
        n_name_len  = r_name_len;
        n_value_len = r_value_len;
        n_tag       = r_tag;
        n_any_kept  = r_any_kept;
        ev          = EV_NONE;
        ch          = 8'd0;

        unique case (eff_state)
            ST_BEGIN: begin
                n_name_len = NL_W'(1);
                n_tag      = (c == tag_char(3'd0));
                n_state    = ST_NAME;
                ev         = EV_NAME_CHAR;
                ch         = c;
            end
            ST_NAME: begin
                if (c == CH_TAB) begin
                    if (r_name_len < NAME_CAP && r_name_len == TAG_LEN && r_tag) begin
                        n_state = ST_CHECK;
                        ev      = EV_TAG;
                    end else begin
                        n_value_len = '0;
                        n_state     = ST_VALUE;
                        ev          = EV_NAME_END;
                    end
                end else if (r_name_len < NAME_CAP) begin
                    n_tag      = r_tag && (r_name_len < TAG_LEN)
                                 && (c == tag_char(r_name_len[2:0]));
                    n_name_len = r_name_len + NL_W'(1);
                    ev         = EV_NAME_CHAR;
                    ch         = c;
                end
            end
            ST_VALUE: begin
                if (c == CH_LF) begin
                    if (r_value_len < VALUE_CAP) begin
                        n_any_kept = 1'b1;
                        ev         = EV_KEPT;
                    end else begin
                        ev = EV_DROPPED;
                    end
                    n_state = ST_BEGIN;
                end else if (c != CH_CR && r_value_len < VALUE_CAP) begin
                    n_value_len = r_value_len + VL_W'(1);
                    ev          = EV_VALUE_CHAR;
                    ch          = c;
                end
            end
            ST_CHECK: begin
                if (sum_add != 8'd0) begin
                    ev = EV_BAD;
                end else if (!r_any_kept) begin
                    ev = EV_EMPTY;
                end else begin
                    ev = EV_GOOD;
                end
                n_sum      = 8'd0;
                n_any_kept = 1'b0;
                n_state    = ST_IDLE;
            end
            ST_HEX: begin
                n_sum   = 8'd0;
                n_state = ST_IDLE;
                ev      = EV_HEX;
            end
            default: begin
                n_state = (c == CH_LF) ? ST_BEGIN : ST_IDLE;
            end
        endcase

        o_res.event_res   = ev;
        o_res.char_out    = ch;
        o_res.running_sum = (eff_state == ST_HEX) ? r_sum : sum_add;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= 8'd0;
            r_name_len  <= '0;
            r_value_len <= '0;
            r_tag       <= 1'b0;
            r_any_kept  <= 1'b0;
        end else if (i_take) begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_name_len  <= n_name_len;
            r_value_len <= n_value_len;
            r_tag       <= n_tag;
            r_any_kept  <= n_any_kept;
        end
    end

    a_hex_clears_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && ev == EV_HEX) |=> (r_sum == 8'd0 && r_state == ST_IDLE))
        else $error("hex abort did not clear the sum");

    a_close_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && (ev == EV_GOOD || ev == EV_BAD || ev == EV_EMPTY))
        |=> (r_state == ST_IDLE && !r_any_kept && r_sum == 8'd0))
        else $error("frame close did not reset frame state");

    a_kept_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && ev == EV_KEPT) |=> (r_any_kept && r_state == ST_BEGIN))
        else $error("kept record not recorded");

    a_char_only_on_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ch != 8'd0) |-> (ev == EV_NAME_CHAR || ev == EV_VALUE_CHAR))
        else $error("character reported outside a character event");

    a_tag_needs_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && ev == EV_TAG) |=> (r_state == ST_CHECK && $past(r_name_len) == TAG_LEN))
        else $error("checksum tag taken with wrong name length");

endmodule

/* rtl/core/tfp_out_stage.sv */
// ----------------------------------------------------------------------------
// tfp_out_stage
// Result register with valid/stall handshake. Loads a new beat whenever it is
// empty or its current beat leaves in the same cycle.
// ----------------------------------------------------------------------------
module tfp_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  tfp_pkg::t_result i_res,
    output logic             o_full_stall,
    output logic             o_valid,
    input  logic             i_stall,
    output tfp_pkg::t_result o_res
);
    import tfp_pkg::*;

    logic    r_valid;
    t_result r_res;

    // hold upstream only while a beat sits here and the receiver stalls
    assign o_full_stall = r_valid & i_stall;
    assign o_valid      = r_valid;
    assign o_res        = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/core/text_record_frame_parser.sv */
// ----------------------------------------------------------------------------
// text_record_frame_parser
// Text record frame parser: splits NAME<tab>VALUE<lf> records, tracks the
// byte sum and reports one event per received byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / o_stall with i_rx_byte, one received byte per
//   beat. Output channel: o_valid / i_stall with o_event_res, o_char_out and
//   o_running_sum, exactly one result beat per input beat, in order.
//   Latency: the result of a byte is presented the cycle after it is taken.
//   Throughput: one byte per clock while o_stall is low; the state update and
//   the result of a byte are formed combinationally from the parser registers.
//   Stall: the result register holds its beat while i_stall is high, and
//   o_stall rises only while that register is full and stalled; when the
//   held beat leaves, a new byte is taken in the same cycle.
//   Reset (i_rst_n low, synchronous): parser returns to idle, byte sum,
//   lengths, tag match and kept-record flag clear, output beat is dropped.
//   NAME_CAPACITY (9..64) and VALUE_CAPACITY (1..64) set the character
//   limits for names and values.
// ----------------------------------------------------------------------------
module text_record_frame_parser #(
    parameter int NAME_CAPACITY  = tfp_pkg::NAME_CAPACITY_DEF,
    parameter int VALUE_CAPACITY = tfp_pkg::VALUE_CAPACITY_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_event_res,
    output logic [7:0] o_char_out,
    output logic [7:0] o_running_sum
);
    import tfp_pkg::*;

    logic    w_take;
    logic    w_full_stall;
    t_result w_res;
    t_result w_out;

    assign o_stall = w_full_stall;
    assign w_take  = i_valid & ~w_full_stall;

    tfp_parser #(
        .NAME_CAPACITY  (NAME_CAPACITY),
        .VALUE_CAPACITY (VALUE_CAPACITY)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_rx_byte (i_rx_byte),
        .o_res     (w_res)
    );

    tfp_out_stage u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_take),
        .i_res        (w_res),
        .o_full_stall (w_full_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_res        (w_out)
    );

    assign o_event_res   = w_out.event_res;
    assign o_char_out    = w_out.char_out;
    assign o_running_sum = w_out.running_sum;

endmodule
